FILE: src/partition_free_space_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the partition free space allocator controller
// ---------------------------------------------------------------------------
`ifndef PARTITION_FREE_SPACE_ALLOCATOR_ASSERT_SVH
`define PARTITION_FREE_SPACE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked during reset
`define PFSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfsa: same-cycle check failed");

// Next-cycle implication, masked during reset
`define PFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfsa: next-cycle check failed");

`endif

FILE: src/pfsa_pkg.sv
// ---------------------------------------------------------------------------
// pfsa_pkg
// Constants, command codes and controller/datapath interface types for the
// partition free space allocator.
// ---------------------------------------------------------------------------
package pfsa_pkg;

  localparam int GPT_SLOTS     = 16;
  localparam int MBR_SLOTS     = 4;
  // Alignment must be a power of two: align-up is an add and a mask
  localparam int ALIGN_SECTORS = 2048;
  localparam int LBA_BITS      = 48;
  localparam int GPT_TAIL      = 34;

  localparam int SLOT_W = 4;
  localparam int PASS_W = $clog2(GPT_SLOTS + 1);

  typedef logic [LBA_BITS-1:0] lba_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;

  localparam lba_t LBA_MAX      = '1;
  localparam lba_t ALIGN_M1     = lba_t'(ALIGN_SECTORS - 1);
  localparam lba_t ALIGN_BASE   = lba_t'(ALIGN_SECTORS);
  localparam lba_t GPT_TAIL_LBA = lba_t'(GPT_TAIL);
  localparam lba_t TOTAL_RESET  = lba_t'(64);

  localparam slot_idx_t MBR_LAST = SLOT_W'(MBR_SLOTS - 1);
  localparam slot_idx_t GPT_LAST = SLOT_W'(GPT_SLOTS - 1);

  // Command kinds
  localparam logic [2:0] KIND_ALLOC  = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_LOAD   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SLOT  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOTAL = 2'd0;
  localparam logic [1:0] CFG_GPT   = 2'd1;

  localparam logic [7:0] GPT_TYPE_MAX     = 8'd3;
  localparam logic [7:0] GPT_TYPE_DEFAULT = 8'd1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SINIT,
    DP_LATCH,
    DP_TEST,
    DP_MOVE,
    DP_EINIT,
    DP_TRIM,
    DP_AVAIL,
    DP_WANT,
    DP_COMMIT,
    DP_WIPE,
    DP_LOAD,
    DP_CLEAR
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_SLOT,
    RES_RANGE
  } res_sel_t;

  typedef struct packed {
    logic       take;
    dp_op_t     op;
    slot_idx_t  idx;
    logic       put;
    res_sel_t   res_sel;
    logic [2:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic gpt;
    logic used_at_idx;
    logic hit;
    logic move_fail;
    logic range_bad;
    logic want_zero;
  } dp_stat_t;

endpackage

FILE: src/pfsa_dp.sv
// ---------------------------------------------------------------------------
// pfsa_dp
// Slot table, configuration registers, start/end search arithmetic and the
// result register of the partition free space allocator.
// ---------------------------------------------------------------------------
module pfsa_dp (
  input  logic                clk,
  input  logic                rst,
  input  pfsa_pkg::dp_cmd_t   cmd,
  output pfsa_pkg::dp_stat_t  stat,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  pfsa_pkg::lba_t      cfg_data,
  input  pfsa_pkg::lba_t      size_sectors,
  input  logic                take_rest,
  input  logic [7:0]          type_code,
  input  logic                boot_in,
  input  logic                used_in,
  input  pfsa_pkg::lba_t      start_in,
  input  pfsa_pkg::lba_t      end_in,
  output logic [2:0]          status,
  output logic [3:0]          slot_out,
  output logic                used_out,
  output logic                boot_out,
  output logic [7:0]          type_out,
  output pfsa_pkg::lba_t      first_out,
  output pfsa_pkg::lba_t      last_out
);
  import pfsa_pkg::*;

  // Configuration
  lba_t disk_size;
  logic gpt_mode;

  // Slot table; an entry without its valid bit reads as all zero
  logic [GPT_SLOTS-1:0] tbl_valid;
  logic [GPT_SLOTS-1:0] tbl_used;
  logic [GPT_SLOTS-1:0] tbl_boot;
  logic [7:0]           tbl_type  [GPT_SLOTS];
  lba_t                 tbl_first [GPT_SLOTS];
  lba_t                 tbl_last  [GPT_SLOTS];

  // Held request payload
  lba_t       req_size;
  logic       req_rest;
  logic [7:0] req_type;
  logic       req_boot;
  logic       req_used;
  lba_t       req_start;
  lba_t       req_end;

  // Search working registers
  lba_t start_lba;
  lba_t stop_lba;
  logic e_used;
  lba_t e_first;
  lba_t e_last;
  lba_t e_next;
  logic hit;
  logic last_max;
  logic end_fail;
  lba_t diff;
  lba_t want_m1;
  logic want_zero;

  // Combinational
  logic              rd_valid;
  logic              rd_used;
  logic              rd_boot;
  logic [7:0]        rd_type;
  lba_t              rd_first;
  lba_t              rd_last;
  logic [LBA_BITS:0] align_sum;
  lba_t              aligned;
  logic              move_fail;
  lba_t              size_m1;
  logic [7:0]        commit_type;
  logic              commit_boot;

  always_comb begin
    rd_valid    = tbl_valid[cmd.idx];
    rd_used     = rd_valid & tbl_used[cmd.idx];
    rd_boot     = rd_valid & tbl_boot[cmd.idx];
    rd_type     = rd_valid ? tbl_type[cmd.idx]  : 8'd0;
    rd_first    = rd_valid ? tbl_first[cmd.idx] : '0;
    rd_last     = rd_valid ? tbl_last[cmd.idx]  : '0;
    align_sum   = {1'b0, e_next} + {1'b0, ALIGN_M1};
    aligned     = align_sum[LBA_BITS-1:0] & ~ALIGN_M1;
    // Skipping past the top sector or aligning beyond it leaves no space
    move_fail   = hit & (last_max | align_sum[LBA_BITS]);
    size_m1     = req_size - lba_t'(1);
    commit_type = gpt_mode ? ((req_type > GPT_TYPE_MAX) ? GPT_TYPE_DEFAULT : req_type)
                           : req_type;
    commit_boot = ~gpt_mode & (cmd.idx == '0);
  end

  assign stat.gpt         = gpt_mode;
  assign stat.used_at_idx = rd_used;
  assign stat.hit         = hit;
  assign stat.move_fail   = move_fail;
  assign stat.range_bad   = end_fail | (start_lba >= stop_lba);
  assign stat.want_zero   = want_zero;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size <= TOTAL_RESET;
      gpt_mode  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL: disk_size <= cfg_data;
        CFG_GPT:   gpt_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else begin
      unique case (cmd.op)
        DP_COMMIT, DP_LOAD: tbl_valid[cmd.idx] <= 1'b1;
        DP_WIPE:            tbl_valid[cmd.idx] <= 1'b0;
        DP_CLEAR:           tbl_valid          <= '0;
        default: ;
      endcase
    end
  end

  // Table payload
  always_ff @(posedge clk) begin
    if (cmd.op == DP_COMMIT) begin
      tbl_used[cmd.idx]  <= 1'b1;
      tbl_boot[cmd.idx]  <= commit_boot;
      tbl_type[cmd.idx]  <= commit_type;
      tbl_first[cmd.idx] <= start_lba;
      tbl_last[cmd.idx]  <= start_lba + want_m1;
    end else if (cmd.op == DP_LOAD) begin
      tbl_used[cmd.idx]  <= req_used;
      tbl_boot[cmd.idx]  <= req_boot;
      tbl_type[cmd.idx]  <= req_type;
      tbl_first[cmd.idx] <= req_start;
      tbl_last[cmd.idx]  <= req_end;
    end
  end

  // Request payload, captured on the input transfer
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_size  <= size_sectors;
      req_rest  <= take_rest;
      req_type  <= type_code;
      req_boot  <= boot_in;
      req_used  <= used_in;
      req_start <= start_in;
      req_end   <= end_in;
    end
  end

  // Start/end search
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_SINIT: begin
          start_lba <= ALIGN_BASE;
          hit       <= 1'b0;
        end
        DP_LATCH: begin
          e_used  <= rd_used;
          e_first <= rd_first;
          e_last  <= rd_last;
        end
        DP_TEST: begin
          hit      <= e_used && (start_lba >= e_first) && (start_lba <= e_last);
          last_max <= (e_last == LBA_MAX);
          e_next   <= e_last + lba_t'(1);
        end
        DP_MOVE: begin
          if (hit && !move_fail) begin
            start_lba <= aligned;
          end
        end
        DP_EINIT: begin
          if (gpt_mode) begin
            end_fail <= (disk_size < GPT_TAIL_LBA);
            stop_lba <= disk_size - GPT_TAIL_LBA;
          end else begin
            end_fail <= (disk_size == '0);
            stop_lba <= disk_size - lba_t'(1);
          end
        end
        DP_TRIM: begin
          // Pull the end in to just before a used entry starting past the start
          if (e_used && (e_first > start_lba) && (e_first <= stop_lba)) begin
            stop_lba <= e_first - lba_t'(1);
          end
        end
        DP_AVAIL: begin
          diff <= stop_lba - start_lba;
        end
        DP_WANT: begin
          want_zero <= ~req_rest & (req_size == '0);
          if (req_rest || (size_m1 > diff)) begin
            want_m1 <= diff;
          end else begin
            want_m1 <= size_m1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      status   <= cmd.res_status;
      slot_out <= cmd.idx;
      unique case (cmd.res_sel)
        RES_SLOT: begin
          used_out  <= rd_used;
          boot_out  <= rd_boot;
          type_out  <= rd_type;
          first_out <= rd_first;
          last_out  <= rd_last;
        end
        RES_RANGE: begin
          used_out  <= 1'b0;
          boot_out  <= 1'b0;
          type_out  <= 8'd0;
          first_out <= start_lba;
          last_out  <= stop_lba;
        end
        default: begin
          used_out  <= 1'b0;
          boot_out  <= 1'b0;
          type_out  <= 8'd0;
          first_out <= '0;
          last_out  <= '0;
        end
      endcase
    end
  end

endmodule

FILE: src/pfsa_ctrl.sv
// ---------------------------------------------------------------------------
// pfsa_ctrl
// Command sequencer: slot scans, start-seek passes, end trim, size check and
// result handoff for the partition free space allocator.
// ---------------------------------------------------------------------------
`include "partition_free_space_allocator_assert.svh"

module pfsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic [3:0]          slot,
  output logic                out_valid,
  input  logic                out_ready,
  output pfsa_pkg::dp_cmd_t   cmd,
  input  pfsa_pkg::dp_stat_t  stat
);
  import pfsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FREE,
    S_SINIT,
    S_SLATCH,
    S_STEST,
    S_SMOVE,
    S_EINIT,
    S_ELATCH,
    S_ETRIM,
    S_CHECK,
    S_WANT,
    S_JUDGE,
    S_DEL,
    S_LOAD,
    S_CLEAR,
    S_PUT
  } state_t;

  state_t              state;
  slot_idx_t           idx;
  slot_idx_t           free_slot;
  logic [PASS_W-1:0]   pass;
  logic                moved;
  res_sel_t            res_sel;
  logic [2:0]          res_status;

  logic      accept;
  logic      put;
  logic      out_wait;
  slot_idx_t last_idx;

  assign last_idx = stat.gpt ? GPT_LAST : MBR_LAST;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign put      = (state == S_PUT) && (!out_valid || out_ready);
  assign out_wait = out_valid & ~out_ready;

  always_comb begin
    cmd.take       = accept;
    cmd.idx        = idx;
    cmd.put        = put;
    cmd.res_sel    = res_sel;
    cmd.res_status = res_status;
    unique case (state)
      S_SINIT:            cmd.op = DP_SINIT;
      S_SLATCH, S_ELATCH: cmd.op = DP_LATCH;
      S_STEST:            cmd.op = DP_TEST;
      S_SMOVE:            cmd.op = DP_MOVE;
      S_EINIT:            cmd.op = DP_EINIT;
      S_ETRIM:            cmd.op = DP_TRIM;
      S_CHECK:            cmd.op = DP_AVAIL;
      S_WANT:             cmd.op = DP_WANT;
      S_JUDGE:            cmd.op = stat.want_zero ? DP_NOP : DP_COMMIT;
      S_DEL:              cmd.op = stat.used_at_idx ? DP_WIPE : DP_NOP;
      S_LOAD:             cmd.op = DP_LOAD;
      S_CLEAR:            cmd.op = DP_CLEAR;
      default:            cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      idx        <= '0;
      free_slot  <= '0;
      pass       <= '0;
      moved      <= 1'b0;
      res_sel    <= RES_ZERO;
      res_status <= ST_OK;
    end else begin
      if (put) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_ALLOC: begin
                idx   <= '0;
                state <= S_FREE;
              end
              KIND_DELETE, KIND_READ, KIND_LOAD: begin
                idx <= slot;
                if (slot > last_idx) begin
                  res_sel    <= RES_ZERO;
                  res_status <= ST_BAD_SLOT;
                  state      <= S_PUT;
                end else if (kind == KIND_DELETE) begin
                  state <= S_DEL;
                end else if (kind == KIND_LOAD) begin
                  state <= S_LOAD;
                end else begin
                  res_sel    <= RES_SLOT;
                  res_status <= ST_OK;
                  state      <= S_PUT;
                end
              end
              KIND_CLEAR: begin
                idx   <= '0;
                state <= S_CLEAR;
              end
              default: begin
                idx        <= '0;
                res_sel    <= RES_ZERO;
                res_status <= ST_OK;
                state      <= S_PUT;
              end
            endcase
          end
        end
        S_FREE: begin
          if (!stat.used_at_idx) begin
            free_slot <= idx;
            state     <= S_SINIT;
          end else if (idx == last_idx) begin
            idx        <= '0;
            res_sel    <= RES_ZERO;
            res_status <= ST_NO_SLOT;
            state      <= S_PUT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SINIT: begin
          idx   <= '0;
          pass  <= '0;
          moved <= 1'b0;
          state <= S_SLATCH;
        end
        S_SLATCH: state <= S_STEST;
        S_STEST:  state <= S_SMOVE;
        S_SMOVE: begin
          if (stat.move_fail) begin
            idx        <= free_slot;
            res_sel    <= RES_ZERO;
            res_status <= ST_NO_SPACE;
            state      <= S_PUT;
          end else if (idx == last_idx) begin
            // Another pass only while the start keeps moving
            if ((moved || stat.hit) && (pass <= PASS_W'(last_idx))) begin
              pass  <= pass + 1'b1;
              moved <= 1'b0;
              idx   <= '0;
              state <= S_SLATCH;
            end else begin
              state <= S_EINIT;
            end
          end else begin
            moved <= moved | stat.hit;
            idx   <= idx + 1'b1;
            state <= S_SLATCH;
          end
        end
        S_EINIT: begin
          idx   <= '0;
          state <= S_ELATCH;
        end
        S_ELATCH: state <= S_ETRIM;
        S_ETRIM: begin
          if (idx == last_idx) begin
            state <= S_CHECK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ELATCH;
          end
        end
        S_CHECK: begin
          idx <= free_slot;
          if (stat.range_bad) begin
            res_sel    <= RES_ZERO;
            res_status <= ST_NO_SPACE;
            state      <= S_PUT;
          end else begin
            state <= S_WANT;
          end
        end
        S_WANT: state <= S_JUDGE;
        S_JUDGE: begin
          if (stat.want_zero) begin
            res_sel    <= RES_RANGE;
            res_status <= ST_BAD_SIZE;
          end else begin
            res_sel    <= RES_SLOT;
            res_status <= ST_OK;
          end
          state <= S_PUT;
        end
        S_DEL: begin
          res_sel    <= RES_SLOT;
          res_status <= stat.used_at_idx ? ST_OK : ST_EMPTY;
          state      <= S_PUT;
        end
        S_LOAD: begin
          res_sel    <= RES_SLOT;
          res_status <= ST_OK;
          state      <= S_PUT;
        end
        S_CLEAR: begin
          res_sel    <= RES_ZERO;
          res_status <= ST_OK;
          state      <= S_PUT;
        end
        S_PUT: begin
          // Hold until the result register is free
          if (put) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFSA_ASSERT_NEXT(a_accept_starts_work, clk, rst, accept, state != S_IDLE)
  `PFSA_ASSERT_NEXT(a_put_holds, clk, rst, (state == S_PUT) && out_wait, (state == S_PUT) && out_valid)
  `PFSA_ASSERT_NOW(a_pass_bound, clk, rst, state == S_SLATCH, pass <= PASS_W'(GPT_SLOTS))
  `PFSA_ASSERT_NOW(a_scan_idx_bound, clk, rst, (state == S_SLATCH) || (state == S_ELATCH), idx <= last_idx)

endmodule

FILE: src/partition_free_space_allocator.sv
// Path to out_valid: read, bad slot and unknown kind go straight to S_PUT; delete, load
//   and clear go via S_DEL, S_LOAD or S_CLEAR; S_PUT waits while an earlier result is held.
// Allocate: free-slot scan, up to n+1 start-seek passes (latch, test, move per slot),
//   end trim (latch, trim per slot), then check, want, judge; n is 4 (MBR) or 16 (GPT).
// One command in flight; the next is taken once the result moves to the output register.
// Reset clears every slot's valid bit, the disk size to 64 and gpt_mode to 0.
// ---------------------------------------------------------------------------
// partition_free_space_allocator
// Top level: partition slot table with first-free-slot, aligned allocation.
// ---------------------------------------------------------------------------
module partition_free_space_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic [3:0]          slot,
  input  pfsa_pkg::lba_t      size_sectors,
  input  logic                take_rest,
  input  logic [7:0]          type_code,
  input  logic                boot_in,
  input  logic                used_in,
  input  pfsa_pkg::lba_t      start_in,
  input  pfsa_pkg::lba_t      end_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [3:0]          slot_out,
  output logic                used_out,
  output logic                boot_out,
  output logic [7:0]          type_out,
  output pfsa_pkg::lba_t      first_out,
  output pfsa_pkg::lba_t      last_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  pfsa_pkg::lba_t      cfg_data
);
  import pfsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .slot      (slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pfsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .size_sectors (size_sectors),
    .take_rest    (take_rest),
    .type_code    (type_code),
    .boot_in      (boot_in),
    .used_in      (used_in),
    .start_in     (start_in),
    .end_in       (end_in),
    .status       (status),
    .slot_out     (slot_out),
    .used_out     (used_out),
    .boot_out     (boot_out),
    .type_out     (type_out),
    .first_out    (first_out),
    .last_out     (last_out)
  );

endmodule

FILE: tb/partition_free_space_allocator_tb.sv
// ---------------------------------------------------------------------------
// partition_free_space_allocator_tb
// Self-checking bench for the partition slot table allocator. A directed
// table covers reset contents, bad slots, unknown kinds, alignment overflow
// and GPT type folding. Randomized phases in MBR and GPT mode then mix
// allocate, delete, read, load and clear commands. Every result is checked
// field by field against its directed row or a local model of the slot table.
// ---------------------------------------------------------------------------
module partition_free_space_allocator_tb;
  import pfsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 13;
  localparam int PHASE_CMDS     = 100;
  localparam logic [63:0] MASK64  = 64'(LBA_MAX);
  localparam logic [63:0] ALIGN64 = 64'(ALIGN_SECTORS);

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    lba_t       size;
    logic       rest;
    logic [7:0] typ;
    logic       boot;
    logic       used;
    lba_t       first;
    lba_t       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic       used;
    logic       boot;
    logic [7:0] typ;
    lba_t       first;
    lba_t       last;
  } report_t;

  typedef struct packed {
    logic    is_cfg;
    lba_t    total;
    logic    gpt;
    logic    typed;
    cmd_t    cmd;
    report_t rep;
  } row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] kind;
  logic [3:0] slot;
  lba_t       size_sectors;
  logic       take_rest;
  logic [7:0] type_code;
  logic       boot_in;
  logic       used_in;
  lba_t       start_in;
  lba_t       end_in;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [3:0] slot_out;
  logic       used_out;
  logic       boot_out;
  logic [7:0] type_out;
  lba_t       first_out;
  lba_t       last_out;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  lba_t       cfg_data;

  // Local copy of the slot table and configuration
  logic       tbl_used  [GPT_SLOTS];
  logic       tbl_boot  [GPT_SLOTS];
  logic [7:0] tbl_type  [GPT_SLOTS];
  lba_t       tbl_first [GPT_SLOTS];
  lba_t       tbl_last  [GPT_SLOTS];
  lba_t       cur_total;
  logic       cur_gpt;

  report_t reports_due[$];
  row_t    dir_rows[$];
  report_t seen;
  int      errors;
  int      out_hold;
  int      idle_cycles;
  logic    no_gaps;

  partition_free_space_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .slot         (slot),
    .size_sectors (size_sectors),
    .take_rest    (take_rest),
    .type_code    (type_code),
    .boot_in      (boot_in),
    .used_in      (used_in),
    .start_in     (start_in),
    .end_in       (end_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot_out     (slot_out),
    .used_out     (used_out),
    .boot_out     (boot_out),
    .type_out     (type_out),
    .first_out    (first_out),
    .last_out     (last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int rand_gap();
    return no_gaps ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic lba_t rand48();
    return lba_t'({$urandom, $urandom});
  endfunction

  function automatic lba_t rand_below(lba_t limit);
    logic [63:0] x;
    x = {$urandom, $urandom};
    return lba_t'(x % 64'(limit));
  endfunction

  function automatic void wipe_entry(int i);
    tbl_used[i]  = 1'b0;
    tbl_boot[i]  = 1'b0;
    tbl_type[i]  = 8'h00;
    tbl_first[i] = '0;
    tbl_last[i]  = '0;
  endfunction

  function automatic report_t entry_report(logic [2:0] st, int i);
    report_t r;
    r = '0;
    r.status = st;
    r.slot   = 4'(i);
    r.used   = tbl_used[i];
    r.boot   = tbl_boot[i];
    r.typ    = tbl_type[i];
    r.first  = tbl_first[i];
    r.last   = tbl_last[i];
    return r;
  endfunction

  // Apply one command to the local slot table and return its report
  function automatic report_t run_table_cmd(cmd_t c);
    report_t     r;
    int          n;
    int          free_s;
    int          pass;
    int          i;
    logic        ok;
    logic        moved;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] q;
    logic [63:0] avail;
    logic [63:0] want;
    r = '0;
    n = cur_gpt ? GPT_SLOTS : MBR_SLOTS;
    case (c.kind)
      KIND_ALLOC: begin
        free_s = n;
        for (i = n - 1; i >= 0; i--)
          if (!tbl_used[i]) free_s = i;
        if (free_s == n) begin
          r.status = ST_NO_SLOT;
          return r;
        end
        ok    = 1'b1;
        moved = 1'b1;
        start = ALIGN64;
        for (pass = 0; moved && ok && pass <= n; pass++) begin
          moved = 1'b0;
          for (i = 0; i < n && ok; i++) begin
            if (tbl_used[i] && start >= 64'(tbl_first[i]) && start <= 64'(tbl_last[i])) begin
              if (64'(tbl_last[i]) == MASK64) begin
                ok = 1'b0;
              end else begin
                start = 64'(tbl_last[i]) + 64'd1;
                if (start % ALIGN64 != 0) begin
                  q = start / ALIGN64 + 64'd1;
                  if (q > MASK64 / ALIGN64) ok = 1'b0;
                  else start = q * ALIGN64;
                end
                moved = 1'b1;
              end
            end
          end
        end
        stop = '0;
        if (ok) begin
          if (cur_gpt) begin
            if (64'(cur_total) < 64'(GPT_TAIL)) ok = 1'b0;
            else stop = 64'(cur_total) - 64'(GPT_TAIL);
          end else begin
            if (cur_total == '0) ok = 1'b0;
            else stop = 64'(cur_total) - 64'd1;
          end
          for (i = 0; i < n; i++)
            if (tbl_used[i] && 64'(tbl_first[i]) > start
                && 64'(tbl_first[i]) - 64'd1 < stop)
              stop = 64'(tbl_first[i]) - 64'd1;
        end
        r.slot = 4'(free_s);
        if (!ok || start >= stop) begin
          r.status = ST_NO_SPACE;
          return r;
        end
        avail = stop - start + 64'd1;
        want  = c.rest ? avail : 64'(c.size);
        if (want == 0) begin
          r.status = ST_BAD_SIZE;
          r.first  = lba_t'(start);
          r.last   = lba_t'(stop);
          return r;
        end
        if (want > avail) want = avail;
        if (cur_gpt) begin
          tbl_type[free_s] = (c.typ > GPT_TYPE_MAX) ? GPT_TYPE_DEFAULT : c.typ;
          tbl_boot[free_s] = 1'b0;
        end else begin
          tbl_type[free_s] = c.typ;
          tbl_boot[free_s] = (free_s == 0);
        end
        tbl_used[free_s]  = 1'b1;
        tbl_first[free_s] = lba_t'(start);
        tbl_last[free_s]  = lba_t'(start + want - 64'd1);
        r = entry_report(ST_OK, free_s);
      end
      KIND_DELETE, KIND_READ, KIND_LOAD: begin
        if (int'(c.slot) >= n) begin
          r.status = ST_BAD_SLOT;
          r.slot   = c.slot;
        end else if (c.kind == KIND_DELETE && !tbl_used[c.slot]) begin
          r = entry_report(ST_EMPTY, c.slot);
        end else begin
          if (c.kind == KIND_DELETE) begin
            wipe_entry(c.slot);
          end else if (c.kind == KIND_LOAD) begin
            tbl_used[c.slot]  = c.used;
            tbl_boot[c.slot]  = c.boot;
            tbl_type[c.slot]  = c.typ;
            tbl_first[c.slot] = c.first;
            tbl_last[c.slot]  = c.last;
          end
          r = entry_report(ST_OK, c.slot);
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < GPT_SLOTS; i++) wipe_entry(i);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   n;
    int   p;
    n      = cur_gpt ? GPT_SLOTS : MBR_SLOTS;
    c      = '0;
    p      = $urandom_range(0, 99);
    c.kind = (p < 42) ? KIND_ALLOC : (p < 57) ? KIND_DELETE : (p < 72) ? KIND_READ :
             (p < 92) ? KIND_LOAD : (p < 95) ? KIND_CLEAR : 3'($urandom_range(5, 7));
    c.slot = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, n - 1))
                                          : 4'($urandom_range(0, 15));
    p = $urandom_range(0, 99);
    if (p < 10)      c.size = '0;
    else if (p < 20) c.size = rand48();
    else if (p < 25) c.size = LBA_MAX;
    else             c.size = lba_t'($urandom_range(1, 1 << 14));
    c.rest = ($urandom_range(0, 3) == 0);
    c.typ  = 8'($urandom);
    c.boot = 1'($urandom);
    c.used = ($urandom_range(0, 9) < 8);
    p = $urandom_range(0, 99);
    if (p < 15) begin
      c.first = rand48();
      c.last  = rand48();
    end else if (p < 20) begin
      // hug the top of the LBA range
      c.first = LBA_MAX - lba_t'($urandom_range(0, 4000));
      c.last  = LBA_MAX - lba_t'($urandom_range(0, 8));
    end else begin
      c.first = rand_below(cur_total);
      if ($urandom_range(0, 1) == 1) c.first = c.first & ~ALIGN_M1;
      if ($urandom_range(0, 3) == 0) c.last = c.first + rand_below(cur_total);
      else c.last = c.first + lba_t'($urandom_range(0, 1 << 15));
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c, logic typed, report_t rep);
    int      gap;
    report_t pred;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= c.kind;
    slot         <= c.slot;
    size_sectors <= c.size;
    take_rest    <= c.rest;
    type_code    <= c.typ;
    boot_in      <= c.boot;
    used_in      <= c.used;
    start_in     <= c.first;
    end_in       <= c.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = run_table_cmd(c);
    reports_due.push_back(typed ? rep : pred);
  endtask

  // Hold off until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(lba_t total, logic gpt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOTAL;
    cfg_data  <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_total = total;
    cfg_index <= CFG_GPT;
    cfg_data  <= lba_t'(gpt);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_gpt = gpt;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_cfg(lba_t total, logic gpt);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.total  = total;
    r.gpt    = gpt;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cmd(cmd_t c, logic typed, report_t rep);
    row_t r;
    r       = '0;
    r.cmd   = c;
    r.typed = typed;
    r.rep   = rep;
    dir_rows.push_back(r);
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = rand_gap();
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("result with none expected: status %0d slot %0d", status, slot_out);
          errors++;
        end else begin
          seen = reports_due.pop_front();
          check_field("status", seen.status, status);
          check_field("slot_out", seen.slot, slot_out);
          check_field("used_out", seen.used, used_out);
          check_field("boot_out", seen.boot, boot_out);
          check_field("type_out", seen.typ, type_out);
          check_field("first_out", seen.first, first_out);
          check_field("last_out", seen.last, last_out);
        end
        out_hold = rand_gap();
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL partition_free_space_allocator");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int ph;
    int k;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_READ;
    slot         = '0;
    size_sectors = '0;
    take_rest    = 1'b0;
    type_code    = '0;
    boot_in      = 1'b0;
    used_in      = 1'b0;
    start_in     = '0;
    end_in       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TOTAL;
    cfg_data     = '0;
    errors       = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    cur_total    = TOTAL_RESET;
    cur_gpt      = 1'b0;
    for (k = 0; k < GPT_SLOTS; k++) wipe_entry(k);

    // Reset contents, 64-sector MBR disk
    add_cmd('{KIND_READ, 4'd0, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_OK, 4'd0, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cmd('{KIND_READ, 4'd4, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_BAD_SLOT, 4'd4, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cmd('{KIND_ALLOC, 4'd0, 48'd8, 1'b0, 8'h83, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_NO_SPACE, 4'd0, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cmd('{3'd7, 4'd9, 48'd5, 1'b1, 8'hFF, 1'b1, 1'b1, 48'd1, 48'd2}, 1'b1,
            '{ST_OK, 4'd0, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cmd('{KIND_DELETE, 4'd1, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_EMPTY, 4'd1, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cmd('{KIND_LOAD, 4'd15, 48'd0, 1'b0, 8'h07, 1'b1, 1'b1, 48'd0, 48'd9}, 1'b1,
            '{ST_BAD_SLOT, 4'd15, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    // 1 Mi-sector MBR disk
    add_cfg(48'd1048576, 1'b0);
    add_cmd('{KIND_ALLOC, 4'd0, 48'd0, 1'b0, 8'h83, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_BAD_SIZE, 4'd0, 1'b0, 1'b0, 8'h00, 48'd2048, 48'd1048575});
    add_cmd('{KIND_ALLOC, 4'd0, 48'd4096, 1'b0, 8'h83, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_OK, 4'd0, 1'b1, 1'b1, 8'h83, 48'd2048, 48'd6143});
    add_cmd('{KIND_ALLOC, 4'd0, 48'd0, 1'b1, 8'h07, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_ALLOC, 4'd0, 48'd1, 1'b0, 8'h0C, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_DELETE, 4'd0, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    // start above end is stored as given
    add_cmd('{KIND_LOAD, 4'd3, 48'd0, 1'b0, 8'hFF, 1'b1, 1'b1, LBA_MAX, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_READ, 4'd3, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    // align-up past the LBA range
    add_cmd('{KIND_LOAD, 4'd2, 48'd0, 1'b0, 8'h83, 1'b0, 1'b1, 48'd0, LBA_MAX - 48'd5},
            1'b0, '0);
    add_cmd('{KIND_ALLOC, 4'd0, 48'd5, 1'b0, 8'h83, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    // used range ending at the last LBA
    add_cmd('{KIND_LOAD, 4'd2, 48'd0, 1'b0, 8'h83, 1'b0, 1'b1, 48'd0, LBA_MAX}, 1'b0, '0);
    add_cmd('{KIND_ALLOC, 4'd0, 48'd5, 1'b0, 8'h83, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_CLEAR, 4'd0, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_OK, 4'd0, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    // Largest GPT disk, type index folding
    add_cfg(LBA_MAX, 1'b1);
    add_cmd('{KIND_ALLOC, 4'd0, LBA_MAX, 1'b0, 8'h09, 1'b1, 1'b1, 48'd0, 48'd0}, 1'b1,
            '{ST_OK, 4'd0, 1'b1, 1'b0, 8'h01, 48'd2048, LBA_MAX - 48'd34});
    add_cmd('{KIND_ALLOC, 4'd0, 48'd3, 1'b0, 8'h02, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_READ, 4'd15, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{KIND_LOAD, 4'd15, 48'd0, 1'b0, 8'h03, 1'b1, 1'b0, 48'd4096, 48'd8191},
            1'b0, '0);
    add_cmd('{KIND_DELETE, 4'd15, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);
    add_cmd('{3'd5, 4'd3, 48'd0, 1'b0, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b1,
            '{ST_OK, 4'd0, 1'b0, 1'b0, 8'h00, 48'd0, 48'd0});
    add_cfg(TOTAL_RESET, 1'b1);
    add_cmd('{KIND_ALLOC, 4'd0, 48'd1, 1'b1, 8'h00, 1'b0, 1'b0, 48'd0, 48'd0}, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_config(dir_rows[i].total, dir_rows[i].gpt);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rep);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      no_gaps = (ph % 4 == 3);
      case ($urandom_range(0, 5))
        0: write_config(TOTAL_RESET + lba_t'($urandom_range(0, 4096)), 1'($urandom));
        1: write_config(lba_t'($urandom_range(8192, 1 << 20)), 1'($urandom));
        2: write_config(lba_t'($urandom_range(1 << 20, 1 << 26)), 1'($urandom));
        3: write_config(rand48() | 48'd64, 1'($urandom));
        4: write_config(LBA_MAX, 1'($urandom));
        default: write_config(lba_t'($urandom_range(64, 40000)), 1'($urandom));
      endcase
      repeat (PHASE_CMDS) send_cmd(rand_cmd(), 1'b0, '0);
    end

    drain();
    if (errors == 0 && reports_due.size() == 0)
      $display("PASS partition_free_space_allocator");
    else
      $display("FAIL partition_free_space_allocator");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/pfsa_pkg.sv
src/pfsa_dp.sv
src/pfsa_ctrl.sv
src/partition_free_space_allocator.sv
tb/partition_free_space_allocator_tb.sv
